// ===== sv/crm_pkg.sv =====
// Package of the calendar rule matcher: sizes, codes, record types and helper functions.
package crm_pkg;

	localparam int ENTRIES = 16;
	localparam int GROUPS = 8;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	// Operation codes of an input word.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Subject codes.
	localparam logic [3:0] SUBJ_WDAY = 4'd0;
	localparam logic [3:0] SUBJ_MONTH = 4'd1;
	localparam logic [3:0] SUBJ_MDAY = 4'd2;
	localparam logic [3:0] SUBJ_MWEEK = 4'd3;
	localparam logic [3:0] SUBJ_NTH_SUN = 4'd4;
	localparam logic [3:0] SUBJ_NTH_MON = 4'd5;
	localparam logic [3:0] SUBJ_NTH_TUE = 4'd6;
	localparam logic [3:0] SUBJ_NTH_WED = 4'd7;
	localparam logic [3:0] SUBJ_NTH_THU = 4'd8;
	localparam logic [3:0] SUBJ_NTH_FRI = 4'd9;
	localparam logic [3:0] SUBJ_NTH_SAT = 4'd10;
	localparam logic [3:0] SUBJ_YEAR = 4'd11;
	localparam logic [3:0] SUBJ_YDAY = 4'd12;
	localparam logic [3:0] SUBJ_YWEEK = 4'd13;
	localparam logic [3:0] SUBJ_DDMM = 4'd14;
	localparam logic [3:0] SUBJ_DDMMYYYY = 4'd15;

	// Comparison codes.
	localparam logic [2:0] CMP_GT = 3'd0;
	localparam logic [2:0] CMP_GE = 3'd1;
	localparam logic [2:0] CMP_EQ = 3'd2;
	localparam logic [2:0] CMP_NE = 3'd3;
	localparam logic [2:0] CMP_LE = 3'd4;
	localparam logic [2:0] CMP_LT = 3'd5;

	localparam logic [11:0] DDMM_SCALE = 12'd100;
	localparam logic [15:0] DDMMYYYY_SCALE = 16'd10000;
	// 37450 / 2^18 is just above 1/7, exact for dividends below 1024.
	localparam logic [15:0] DIV7_RECIP = 16'd37450;

	typedef struct packed {
		logic [2:0]  group;
		logic [3:0]  subject;
		logic [2:0]  compare;
		logic [15:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [2:0]  wday;
		logic [8:0]  yday;
	} date_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [2:0]  wday;
		logic [8:0]  yday;
		logic [2:0]  mweek;
		logic [2:0]  nth;
		logic [6:0]  yweek;
		logic [11:0] ddmm;
		logic [15:0] ddmmyyyy;
	} subj_t;

	// Floor of x / 7 for x below 1024.
	function automatic logic [7:0] div7(input logic [9:0] x);
		logic [25:0] prod;
		prod = 26'(x) * 26'(DIV7_RECIP);
		return prod[25:18];
	endfunction

endpackage

// ===== sv/crm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module crm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/crm_date.sv =====
// Two-stage pipeline that derives all date subjects from a broken-down date.
module crm_date (
	input  logic           clk,
	input  crm_pkg::date_t date,
	output crm_pkg::subj_t subj
);
	import crm_pkg::*;

	subj_t s1_c;
	subj_t s2_c;
	subj_t subj_s1;
	subj_t subj_s2;
	logic [7:0] mweek_div;
	logic [7:0] nth_div;
	logic [7:0] yweek_div;
	logic [15:0] dmy_prod;

	// Stage one: week numbers through the reciprocal of 7, and DDMM.
	always_comb begin
		mweek_div = div7(10'(date.mday) + 10'd12 - 10'(date.wday));
		nth_div = div7(10'(date.mday) + 10'd6);
		yweek_div = div7(10'(date.yday) + 10'd13 - 10'(date.wday));
		s1_c = '0;
		s1_c.year = date.year;
		s1_c.month = date.month;
		s1_c.mday = date.mday;
		s1_c.wday = date.wday;
		s1_c.yday = date.yday;
		s1_c.mweek = mweek_div[2:0];
		s1_c.nth = nth_div[2:0];
		s1_c.yweek = yweek_div[6:0];
		s1_c.ddmm = 12'(12'(date.mday) * DDMM_SCALE) + 12'(date.month);
	end

	always_ff @(posedge clk) begin
		subj_s1 <= s1_c;
	end

	// Stage two: DDMMYYYY, kept to 16 bits.
	assign dmy_prod = 16'(subj_s1.ddmm) * DDMMYYYY_SCALE;

	always_comb begin
		s2_c = subj_s1;
		s2_c.ddmmyyyy = dmy_prod + 16'(subj_s1.year);
	end

	always_ff @(posedge clk) begin
		subj_s2 <= s2_c;
	end

	assign subj = subj_s2;

endmodule

// ===== sv/crm_eval.sv =====
// Tests one table entry against the derived date subjects.
module crm_eval (
	input  crm_pkg::entry_t entry,
	input  crm_pkg::subj_t  subj,
	output logic            holds
);
	import crm_pkg::*;

	logic [15:0] s;
	logic        known;
	logic        cmp;

	always_comb begin
		known = 1'b1;
		s = '0;
		case (entry.subject) inside
			SUBJ_WDAY:  s = 16'(subj.wday);
			SUBJ_MONTH: s = 16'(subj.month);
			SUBJ_MDAY:  s = 16'(subj.mday);
			SUBJ_MWEEK: s = 16'(subj.mweek);
			[SUBJ_NTH_SUN:SUBJ_NTH_SAT]: begin
				// The entry only applies on its own weekday.
				known = (4'(subj.wday) == (entry.subject - SUBJ_NTH_SUN));
				s = 16'(subj.nth);
			end
			SUBJ_YEAR:     s = 16'(subj.year);
			SUBJ_YDAY:     s = 16'(subj.yday);
			SUBJ_YWEEK:    s = 16'(subj.yweek);
			SUBJ_DDMM:     s = 16'(subj.ddmm);
			SUBJ_DDMMYYYY: s = subj.ddmmyyyy;
			default:       known = 1'b0;
		endcase
	end

	always_comb begin
		unique case (entry.compare)
			CMP_GT:  cmp = (s > entry.value);
			CMP_GE:  cmp = (s >= entry.value);
			CMP_EQ:  cmp = (s == entry.value);
			CMP_NE:  cmp = (s != entry.value);
			CMP_LE:  cmp = (s <= entry.value);
			CMP_LT:  cmp = (s < entry.value);
			default: cmp = 1'b0;
		endcase
	end

	assign holds = known & cmp;

endmodule

// ===== sv/calendar_rule_matcher.sv =====
// Top level of the calendar rule matcher: command port, table sequencer and group tally.
// A write word is acknowledged on done in the cycle after it is taken; busy stays low.
// An evaluate word holds busy through the PREP, SCAN and FIN states; its answer is registered onto done from FIN.
// The evaluation time is set by one pass over the table, one entry read per cycle from the RAM,
// plus the PREP state that primes the date pipeline and the FIN state that tallies the last
// entry; the receiver cannot stall, and writes can follow each other every cycle.
// Asynchronous reset marks all table entries invalid and returns the sequencer to idle.
module calendar_rule_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [3:0]  entry_index,
	input  logic        entry_valid,
	input  logic [2:0]  entry_group,
	input  logic [3:0]  entry_subject,
	input  logic [2:0]  entry_compare,
	input  logic [15:0] entry_value,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	input  logic [2:0]  weekday,
	input  logic [8:0]  day_of_year,
	output logic        done,
	output logic        applies,
	output logic        was_write
);
	import crm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	logic [1:0]         state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [ENTRIES-1:0] vld_q;
	logic [GROUPS-1:0]  seen_q;
	logic [GROUPS-1:0]  allok_q;
	logic [GROUPS-1:0]  seen_nx;
	logic [GROUPS-1:0]  allok_nx;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               done_q;
	logic               applies_q;
	logic               was_write_q;
	date_t              date_q;
	subj_t              subj;
	entry_t             wr_entry;
	entry_t             rd_entry;
	logic               accept;
	logic               wr_en;
	logic               rd_en;
	logic               holds;
	logic               counted;

	assign busy = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign wr_en = accept & (operation == OP_WRITE) & (32'(entry_index) < ENTRIES);
	assign rd_en = (state_q == ST_SCAN);

	assign wr_entry.group = entry_group;
	assign wr_entry.subject = entry_subject;
	assign wr_entry.compare = entry_compare;
	assign wr_entry.value = entry_value;

	crm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(entry_index)),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (cnt_q),
		.rdata (rd_entry)
	);

	crm_date u_date (
		.clk  (clk),
		.date (date_q),
		.subj (subj)
	);

	crm_eval u_eval (
		.entry (rd_entry),
		.subj  (subj),
		.holds (holds)
	);

	// An entry read back this cycle counts only if it is valid and names an existing group.
	assign counted = rd_vld_s1 & vld_q[rd_idx_s1] & (32'(rd_entry.group) < GROUPS);

	always_comb begin
		seen_nx = seen_q;
		allok_nx = allok_q;
		if (state_q == ST_IDLE) begin
			// Each table pass starts from empty group sets.
			seen_nx = '0;
			allok_nx = '1;
		end else if (counted) begin
			seen_nx[GRP_IDX_W'(rd_entry.group)] = 1'b1;
			if (!holds) begin
				allok_nx[GRP_IDX_W'(rd_entry.group)] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_EVAL) begin
			date_q.year <= year;
			date_q.month <= month;
			date_q.mday <= day_of_month;
			date_q.wday <= weekday;
			date_q.yday <= day_of_year;
		end
		rd_idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			vld_q <= '0;
			seen_q <= '0;
			allok_q <= '1;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
			applies_q <= 1'b0;
			was_write_q <= 1'b0;
		end else begin
			done_q <= (accept && operation == OP_WRITE) || (state_q == ST_FIN);
			rd_vld_s1 <= rd_en;
			seen_q <= seen_nx;
			allok_q <= allok_nx;
			if (wr_en) begin
				vld_q[IDX_W'(entry_index)] <= entry_valid;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_WRITE) begin
							applies_q <= 1'b0;
							was_write_q <= 1'b1;
						end else begin
							state_q <= ST_PREP;
							cnt_q <= '0;
						end
					end
				end
				ST_PREP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					// The last entry is tallied here, so the answer uses the next-state sets.
					state_q <= ST_IDLE;
					applies_q <= |(seen_nx & allok_nx);
					was_write_q <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign applies = applies_q;
	assign was_write = was_write_q;

`ifndef NO_ASSERTIONS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while busy");

	a_write_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_write) |-> !applies)
		else $error("write acknowledge carries a match");

	a_eval_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_EVAL) |=> (busy && !done))
		else $error("evaluate word did not start a table pass");

	a_write_acked: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_WRITE) |=> (done && was_write))
		else $error("write word not acknowledged");

	a_scan_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> rd_vld_s1)
		else $error("table read not tracked");
`endif

endmodule
